@@ sv/dmmp_pkg.sv @@
`default_nettype none
package dmmp_pkg;

  localparam int NODE_FW  = 7;
  localparam int COST_FW  = 16;
  localparam int EDGES_FW = 6;

  localparam int MAX_NODES_DEF     = 64;
  localparam int MAX_EDGES_DEF     = 1024;
  localparam int SEARCH_STEPS_DEF  = 40;
  localparam int FRACTION_BITS_DEF = 16;

  localparam logic [NODE_FW-1:0] NODE_COUNT_RST = 7'd64;

  typedef struct packed {
    logic [NODE_FW-1:0] from;
    logic [NODE_FW-1:0] to;
    logic [COST_FW-1:0] cost;
  } edge_t;

  localparam int EDGE_W = $bits(edge_t);

endpackage
`default_nettype wire

@@ sv/dmmp_ram.sv @@
`default_nettype none
module dmmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ sv/dag_min_mean_path_unit.sv @@
// Edges load at one item per cycle while idle (in_stall_o low). An item with
// last_edge starts the search: SEARCH_STEPS+1 relaxation passes, each visiting
// every node and, for every reached source, reading its cost and checking every
// stored edge, all through one shared add/compare unit and the RAMs. Path output
// then walks the predecessors back from the target and emits each node of the
// path. Reset (async, active low) clears control state, edge count and
// node_count=64.
`default_nettype none
module dag_min_mean_path_unit #(
  parameter int MAX_NODES     = dmmp_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES     = dmmp_pkg::MAX_EDGES_DEF,
  parameter int SEARCH_STEPS  = dmmp_pkg::SEARCH_STEPS_DEF,
  parameter int FRACTION_BITS = dmmp_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [dmmp_pkg::NODE_FW-1:0]   edge_from_i,
  input  wire logic [dmmp_pkg::NODE_FW-1:0]   edge_to_i,
  input  wire logic [dmmp_pkg::COST_FW-1:0]   edge_cost_i,
  input  wire logic                           last_edge_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic      [dmmp_pkg::NODE_FW-1:0]   path_node_o,
  output logic      [dmmp_pkg::EDGES_FW-1:0]  path_edges_o,
  output logic                                path_last_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [1:0]                     paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready
);

  localparam int NW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int XW  = (NW + 1 > dmmp_pkg::NODE_FW) ? NW + 1 : dmmp_pkg::NODE_FW;
  localparam int AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EW  = $clog2(MAX_EDGES + 1);
  localparam int SW  = $clog2(SEARCH_STEPS + 1);
  localparam int BW  = FRACTION_BITS + 18;
  localparam int CW  = FRACTION_BITS + dmmp_pkg::COST_FW + NW + 2;
  localparam int FW  = dmmp_pkg::NODE_FW;

  localparam logic signed [BW-1:0] LO_RST = -(BW'(1) <<< FRACTION_BITS);
  localparam logic signed [BW-1:0] HI_RST = BW'(65536) <<< FRACTION_BITS;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_TINIT = 14'b00000000000010,
    S_NODE  = 14'b00000000000100,
    S_COSTU = 14'b00000000001000,
    S_ERD   = 14'b00000000010000,
    S_ECHK  = 14'b00000000100000,
    S_RELAX = 14'b00000001000000,
    S_TRD   = 14'b00000010000000,
    S_TEND  = 14'b00000100000000,
    S_WST   = 14'b00001000000000,
    S_WRD   = 14'b00010000000000,
    S_OSET  = 14'b00100000000000,
    S_ORD   = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_e;

  state_e                  state_q, state_d;
  logic [FW-1:0]           node_count_q, node_count_d;
  logic [EW-1:0]           total_q, total_d;
  logic [XW-1:0]           n_q, n_d;
  logic signed [BW-1:0]    lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [SW-1:0]           step_q, step_d;
  logic                    final_q, final_d;
  logic [MAX_NODES-1:0]    reached_q, reached_d;
  logic [XW-1:0]           u_q, u_d;
  logic [EW-1:0]           e_q, e_d;
  logic signed [CW-1:0]    cadj_q, cadj_d, cand_q, cand_d;
  logic [NW-1:0]           tidx_q, tidx_d, cur_q, cur_d;
  logic [NW:0]             len_q, len_d, k_q, k_d;
  logic                    ovalid_q, ovalid_d, olast_q, olast_d;
  logic [FW-1:0]           onode_q, onode_d;
  logic [dmmp_pkg::EDGES_FW-1:0] oedges_q, oedges_d;

  logic                    edge_we;
  dmmp_pkg::edge_t         edge_wdata, edge_rdata;
  logic [AW-1:0]           edge_raddr;
  logic                    cost_we;
  logic [NW-1:0]           cost_addr_r;
  logic [CW-1:0]           cost_rdata;
  logic [NW-1:0]           pred_raddr;
  logic [NW-1:0]           pred_rdata;
  logic                    stack_we;
  logic [NW-1:0]           stack_raddr;
  logic [NW-1:0]           stack_rdata;

  logic [XW-1:0]           ef, et, nc;
  logic                    edge_ok, better, feasible;
  logic [NW-1:0]           uidx, target;
  logic signed [CW-1:0]    cost_rs, cost_u, weight;
  logic signed [BW:0]      bsum;

  dmmp_ram #(.WIDTH(dmmp_pkg::EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (total_q[AW-1:0]),
    .wdata_i (edge_wdata),
    .raddr_i (edge_raddr),
    .rdata_o (edge_rdata)
  );

  dmmp_ram #(.WIDTH(CW), .DEPTH(MAX_NODES)) u_cost_ram (
    .clk_i   (clk_i),
    .we_i    (cost_we),
    .waddr_i (tidx_q),
    .wdata_i (cand_q),
    .raddr_i (cost_addr_r),
    .rdata_o (cost_rdata)
  );

  dmmp_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_pred_ram (
    .clk_i   (clk_i),
    .we_i    (cost_we),
    .waddr_i (tidx_q),
    .wdata_i (uidx),
    .raddr_i (pred_raddr),
    .rdata_o (pred_rdata)
  );

  dmmp_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stack_we),
    .waddr_i (len_q[NW-1:0]),
    .wdata_i (cur_q),
    .raddr_i (stack_raddr),
    .rdata_o (stack_rdata)
  );

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = ovalid_q;
  assign path_node_o  = onode_q;
  assign path_edges_o = oedges_q;
  assign path_last_o  = olast_q;
  assign pready       = 1'b1;
  assign prdata       = {{(32 - FW){1'b0}}, node_count_q};

  assign edge_wdata = '{from: edge_from_i, to: edge_to_i, cost: edge_cost_i};
  assign edge_raddr = e_q[AW-1:0];
  assign edge_we    = (state_q == S_IDLE) && in_valid_i && (total_q < EW'(MAX_EDGES));

  assign ef      = XW'(edge_rdata.from);
  assign et      = XW'(edge_rdata.to);
  assign edge_ok = (ef != '0) && (ef < et) && (et <= n_q) && ((ef - XW'(1)) == u_q);
  assign uidx    = u_q[NW-1:0];
  assign target  = NW'(n_q - XW'(1));
  assign cost_rs = $signed(cost_rdata);
  assign cost_u  = (u_q == '0) ? '0 : cost_rs;
  assign weight  = $signed({{(CW - dmmp_pkg::COST_FW - FRACTION_BITS){1'b0}},
                            edge_rdata.cost, {FRACTION_BITS{1'b0}}});
  assign bsum    = (BW + 1)'(lo_q) + (BW + 1)'(hi_q);
  assign better  = !reached_q[tidx_q] || (cand_q < cost_rs);
  assign feasible = reached_q[target] && (cost_rs[CW-1] || (cost_rs == '0));
  assign nc      = XW'(node_count_q);

  assign cost_we  = (state_q == S_RELAX) && better;
  assign stack_we = (state_q == S_WST);
  assign pred_raddr  = cur_q;
  assign stack_raddr = NW'(len_q - k_q - (NW + 1)'(1));

  always_comb begin
    cost_addr_r = uidx;
    case (state_q)
      S_ECHK:  cost_addr_r = NW'(et - XW'(1));
      S_TRD:   cost_addr_r = target;
      default: cost_addr_r = uidx;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    node_count_d = node_count_q;
    total_d      = total_q;
    n_d          = n_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    step_d       = step_q;
    final_d      = final_q;
    reached_d    = reached_q;
    u_d          = u_q;
    e_d          = e_q;
    cadj_d       = cadj_q;
    cand_d       = cand_q;
    tidx_d       = tidx_q;
    cur_d        = cur_q;
    len_d        = len_q;
    k_d          = k_q;
    ovalid_d     = ovalid_q;
    onode_d      = onode_q;
    oedges_d     = oedges_q;
    olast_d      = olast_q;

    if (psel && penable && pwrite) begin
      node_count_d = pwdata[FW-1:0];
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (edge_we) begin
            total_d = total_q + EW'(1);
          end
          if (last_edge_i) begin
            if (nc < XW'(2)) begin
              n_d = XW'(2);
            end else if (nc > XW'(MAX_NODES)) begin
              n_d = XW'(MAX_NODES);
            end else begin
              n_d = nc;
            end
            lo_d    = LO_RST;
            hi_d    = HI_RST;
            step_d  = '0;
            final_d = 1'b0;
            state_d = S_TINIT;
          end
        end
      end
      S_TINIT: begin
        mid_d     = final_q ? hi_q : BW'(bsum >>> 1);
        reached_d = MAX_NODES'(1);
        u_d       = '0;
        state_d   = S_NODE;
      end
      S_NODE: begin
        if (u_q == n_q) begin
          state_d = S_TRD;
        end else if (!reached_q[uidx]) begin
          u_d = u_q + XW'(1);
        end else begin
          state_d = S_COSTU;
        end
      end
      S_COSTU: begin
        cadj_d = cost_u - CW'(mid_q);
        e_d    = '0;
        if (total_q == '0) begin
          u_d     = u_q + XW'(1);
          state_d = S_NODE;
        end else begin
          state_d = S_ERD;
        end
      end
      S_ERD: begin
        state_d = S_ECHK;
      end
      S_ECHK: begin
        cand_d = cadj_q + weight;
        tidx_d = NW'(et - XW'(1));
        if (edge_ok) begin
          state_d = S_RELAX;
        end else if (e_q + EW'(1) == total_q) begin
          u_d     = u_q + XW'(1);
          state_d = S_NODE;
        end else begin
          e_d     = e_q + EW'(1);
          state_d = S_ERD;
        end
      end
      S_RELAX: begin
        if (better) begin
          reached_d[tidx_q] = 1'b1;
        end
        if (e_q + EW'(1) == total_q) begin
          u_d     = u_q + XW'(1);
          state_d = S_NODE;
        end else begin
          e_d     = e_q + EW'(1);
          state_d = S_ERD;
        end
      end
      S_TRD: begin
        state_d = S_TEND;
      end
      S_TEND: begin
        if (final_q) begin
          cur_d   = target;
          len_d   = '0;
          state_d = S_WST;
        end else begin
          if (feasible) begin
            hi_d = mid_q;
          end else begin
            lo_d = mid_q;
          end
          step_d = step_q + SW'(1);
          if (step_q + SW'(1) == SW'(SEARCH_STEPS)) begin
            final_d = 1'b1;
          end
          state_d = S_TINIT;
        end
      end
      S_WST: begin
        len_d = len_q + (NW + 1)'(1);
        if (reached_q[cur_q] && (cur_q != '0)) begin
          state_d = S_WRD;
        end else begin
          k_d     = '0;
          state_d = S_OSET;
        end
      end
      S_WRD: begin
        cur_d   = pred_rdata;
        state_d = S_WST;
      end
      S_OSET: begin
        state_d = S_ORD;
      end
      S_ORD: begin
        ovalid_d = 1'b1;
        onode_d  = FW'(stack_rdata) + FW'(1);
        oedges_d = dmmp_pkg::EDGES_FW'(len_q - (NW + 1)'(1));
        olast_d  = (k_q == len_q - (NW + 1)'(1));
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          ovalid_d = 1'b0;
          if (olast_q) begin
            total_d = '0;
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + (NW + 1)'(1);
            state_d = S_OSET;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      node_count_q <= dmmp_pkg::NODE_COUNT_RST;
      total_q      <= '0;
      lo_q         <= LO_RST;
      hi_q         <= HI_RST;
      step_q       <= '0;
      final_q      <= 1'b0;
      reached_q    <= '0;
      ovalid_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      node_count_q <= node_count_d;
      total_q      <= total_d;
      lo_q         <= lo_d;
      hi_q         <= hi_d;
      step_q       <= step_d;
      final_q      <= final_d;
      reached_q    <= reached_d;
      ovalid_q     <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    mid_q    <= mid_d;
    u_q      <= u_d;
    e_q      <= e_d;
    cadj_q   <= cadj_d;
    cand_q   <= cand_d;
    tidx_q   <= tidx_d;
    cur_q    <= cur_d;
    len_q    <= len_d;
    k_q      <= k_d;
    onode_q  <= onode_d;
    oedges_q <= oedges_d;
    olast_q  <= olast_d;
  end

  a_valid_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (state_q == S_OUT))
    else $error("result valid outside output state");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && path_last_o) |=> !in_stall_o)
    else $error("no return to idle after final node");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= EW'(MAX_EDGES))
    else $error("edge count overflow");

  a_source_reached: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RELAX) |-> (reached_q[0] && reached_q[uidx]))
    else $error("relaxing from unreached source");

endmodule
`default_nettype wire
